@@ design/imu_sensor_report_unpacker_core_macros.svh @@
// Assertion macros shared by the sensor report unpacker RTL.
// Expects clk_i and rst_ni in scope of the module that uses them.
`ifndef IMU_SENSOR_REPORT_UNPACKER_CORE_MACROS_SVH
`define IMU_SENSOR_REPORT_UNPACKER_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset
`define IMU_UNP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen outside reset
`define IMU_UNP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ design/imu_unp_pkg.sv @@
// Shared types, constants and unpacking functions for the sensor report unpacker.
// No dependencies.
`default_nettype none

package imu_unp_pkg;

  localparam int unsigned DefSampleSlots = 3;
  localparam int unsigned DefReportBytes = 64;

  localparam logic [7:0]  ReportId   = 8'h01;
  localparam int unsigned HdrLen     = 8;
  localparam int unsigned SlotLen    = 16;
  localparam int unsigned MagLen     = 6;
  localparam int unsigned VecW       = 21;
  localparam int unsigned RawW       = SlotLen * 8;
  localparam int unsigned OutDataW   = 168;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    KindInertial = 1'b0,
    KindMag      = 1'b1
  } kind_e;

  // One queued result: header copy plus the raw slot or magnetometer bytes
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       num_samples;
    logic [15:0]      timestamp;
    logic [15:0]      temperature;
    logic [1:0]       sample_index;
    logic [RawW-1:0]  raw;
  } imu_entry_t;

  typedef struct packed {
    logic [VecW-1:0] z;
    logic [VecW-1:0] y;
    logic [VecW-1:0] x;
  } vec_t;

  // Big-endian 8-byte group to three 21-bit fields
  function automatic vec_t unpack_group(input logic [63:0] w);
    vec_t v;
    v.x = w[63:43];
    v.y = w[42:22];
    v.z = w[21:1];
    return v;
  endfunction

  // Little-endian signed 16-bit pair, sign-extended to 21 bits
  function automatic logic [VecW-1:0] mag_ext(input logic [7:0] lo, input logic [7:0] hi);
    return {{(VecW-16){hi[7]}}, hi, lo};
  endfunction

endpackage

`default_nettype wire

@@ design/imu_sensor_report_unpacker_core.sv @@
// Channel       Dir  Beat content
// s_axis        in   tdata: data_byte[7:0]; tuser: first_byte
// m_axis        out  tdata: sample and header fields (168 bits); tuser: kind; tlast: last
//
// One byte beat per cycle is taken while the result queue has room.
// A result goes from its closing byte into the result queue and from there into the output register.
// Reset (rst_ni low) leaves the block idle until a first byte arrives.
// A stalled output fills the two-entry queue; only then is s_axis held off.
//
// Top level of the sensor report unpacker; depends on imu_unp_pkg,
// imu_unp_front, imu_unp_queue and imu_unp_back.
`default_nettype none

module imu_sensor_report_unpacker_core import imu_unp_pkg::*; #(
  parameter int unsigned SAMPLE_SLOTS = DefSampleSlots,
  parameter int unsigned REPORT_BYTES = DefReportBytes
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // data_byte[7:0]
  input  wire logic [0:0]           s_axis_tuser,   // first_byte[0]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // num_samples[7:0], timestamp[23:8], temperature[39:24], sample_index[41:40],
  // vec_a_x[62:42], vec_a_y[83:63], vec_a_z[104:84],
  // vec_b_x[125:105], vec_b_y[146:126], vec_b_z[167:147]
  output logic [OutDataW-1:0]       m_axis_tdata,
  output logic [0:0]                m_axis_tuser,   // kind[0]
  output logic                      m_axis_tlast    // last_of_report
);

  logic       q_full, q_empty, push, pop;
  imu_entry_t push_entry, head;

  imu_unp_front #(
    .SampleSlots (SAMPLE_SLOTS),
    .ReportBytes (REPORT_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_first_i   (s_axis_tuser[0]),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  imu_unp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .empty_o      (q_empty),
    .pop_i        (pop),
    .head_o       (head)
  );

  imu_unp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser[0]),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ design/imu_unp_front.sv @@
// Front end: byte position tracking, header capture and slot/magnetometer collection.
// Depends on imu_unp_pkg; pushes finished result entries into imu_unp_queue.
`default_nettype none

module imu_unp_front import imu_unp_pkg::*; #(
  parameter int unsigned SampleSlots = DefSampleSlots,
  parameter int unsigned ReportBytes = DefReportBytes
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_first_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output imu_entry_t      push_entry_o
);

  `include "imu_sensor_report_unpacker_core_macros.svh"

  localparam int unsigned PosW    = $clog2(ReportBytes + 1);
  localparam int unsigned SlotW   = PosW - 4;
  localparam int unsigned MagBase = HdrLen + SlotLen * SampleSlots;

  logic [PosW-1:0]       pos_q, pos_d, pos_eff, pos_m8;
  logic                  valid_q, valid_d;
  logic [7:0]            count_q, count_d;
  logic [15:0]           ts_q, ts_d;
  logic [15:0]           temp_q, temp_d;
  logic [RawW-9:0]       slot_sr_q, slot_sr_d;
  logic [8*MagLen-9:0]   mag_sr_q, mag_sr_d;
  logic                  accept, live, act, in_slot, in_mag;
  logic [SlotW-1:0]      slot_num;
  logic                  slot_emit, mag_emit;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Position of this beat; a first byte restarts at zero
  assign pos_eff  = in_first_i ? '0 : pos_q;
  assign live     = pos_eff < PosW'(ReportBytes);
  assign act      = accept && live && valid_q && (pos_eff != '0);
  assign pos_m8   = pos_eff - PosW'(HdrLen);
  assign slot_num = pos_m8[PosW-1:4];
  assign in_slot  = (pos_eff >= PosW'(HdrLen)) && (pos_eff < PosW'(MagBase));
  assign in_mag   = (pos_eff >= PosW'(MagBase)) && (pos_eff < PosW'(MagBase + MagLen));

  assign slot_emit = act && in_slot && (pos_m8[3:0] == 4'(SlotLen - 1))
                     && (8'(slot_num) < count_q);
  assign mag_emit  = act && (pos_eff == PosW'(MagBase + MagLen - 1));

  // Next state of position, id check, header fields and byte shift registers
  always_comb begin
    pos_d     = pos_q;
    valid_d   = valid_q;
    count_d   = count_q;
    ts_d      = ts_q;
    temp_d    = temp_q;
    slot_sr_d = slot_sr_q;
    mag_sr_d  = mag_sr_q;
    if (accept && live) begin
      pos_d = pos_eff + PosW'(1);
      if (pos_eff == '0) begin
        valid_d = (in_byte_i == ReportId);
      end
    end
    if (act) begin
      priority if (pos_eff == PosW'(1)) begin
        count_d = in_byte_i;
      end else if (pos_eff == PosW'(2)) begin
        ts_d[7:0] = in_byte_i;
      end else if (pos_eff == PosW'(3)) begin
        ts_d[15:8] = in_byte_i;
      end else if (pos_eff == PosW'(6)) begin
        temp_d[7:0] = in_byte_i;
      end else if (pos_eff == PosW'(7)) begin
        temp_d[15:8] = in_byte_i;
      end else if (in_slot) begin
        slot_sr_d = {slot_sr_q[RawW-17:0], in_byte_i};
      end else if (in_mag) begin
        mag_sr_d = {mag_sr_q[8*MagLen-17:0], in_byte_i};
      end else begin
        // reserved and trailing bytes change nothing
        count_d = count_q;
      end
    end
  end

  // Control and header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= PosW'(ReportBytes);
      valid_q <= 1'b0;
      count_q <= '0;
      ts_q    <= '0;
      temp_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
      count_q <= count_d;
      ts_q    <= ts_d;
      temp_q  <= temp_d;
    end
  end

  // Byte collection shift registers, not reset
  always_ff @(posedge clk_i) begin
    slot_sr_q <= slot_sr_d;
    mag_sr_q  <= mag_sr_d;
  end

  // Result entry for the queue
  always_comb begin
    push_o                    = slot_emit || mag_emit;
    push_entry_o.num_samples  = count_q;
    push_entry_o.timestamp    = ts_q;
    push_entry_o.temperature  = temp_q;
    if (mag_emit) begin
      push_entry_o.kind         = KindMag;
      push_entry_o.sample_index = '0;
      push_entry_o.raw          = RawW'({mag_sr_q, in_byte_i});
    end else begin
      push_entry_o.kind         = KindInertial;
      push_entry_o.sample_index = 2'(slot_num);
      push_entry_o.raw          = {slot_sr_q, in_byte_i};
    end
  end

  `IMU_UNP_ASSERT(a_pos_range, pos_q <= PosW'(ReportBytes), "byte position out of range")
  `IMU_UNP_NEVER(a_emit_both, slot_emit && mag_emit, "slot and magnetometer result together")

endmodule

`default_nettype wire

@@ design/imu_unp_queue.sv @@
// Short result queue between the front end and the output stage.
// Depends on imu_unp_pkg for the entry type and depth.
`default_nettype none

module imu_unp_queue import imu_unp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  imu_entry_t       push_entry_i,
  output logic             full_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  output imu_entry_t       head_o
);

  `include "imu_sensor_report_unpacker_core_macros.svh"

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  imu_entry_t      store_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = store_q[rd_q];

  // Pointer and fill count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= push_entry_i;
    end
  end

  `IMU_UNP_NEVER(a_push_full, push_i && full_o, "push into a full queue")
  `IMU_UNP_ASSERT(a_cnt_bound, cnt_q <= CntW'(QueueDepth), "queue count overflow")

endmodule

`default_nettype wire

@@ design/imu_unp_back.sv @@
// Output stage: unpacks queued entries into vectors and holds the result beat.
// Depends on imu_unp_pkg; pops from imu_unp_queue.
`default_nettype none

module imu_unp_back import imu_unp_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  imu_entry_t               head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_kind_o,
  output logic                     out_last_o
);

  `include "imu_sensor_report_unpacker_core_macros.svh"

  logic                valid_q, valid_d;
  logic [OutDataW-1:0] data_q, data_d;
  logic                kind_q, kind_d, last_q, last_d;
  vec_t                vec_a, vec_b;

  assign pop_o = !q_empty_i && (!valid_q || out_ready_i);

  // Unpack the head entry; magnetometer bytes sit oldest first from bit 47 down
  always_comb begin
    if (head_i.kind == KindMag) begin
      vec_a.x = mag_ext(head_i.raw[47:40], head_i.raw[39:32]);
      vec_a.y = mag_ext(head_i.raw[31:24], head_i.raw[23:16]);
      vec_a.z = mag_ext(head_i.raw[15:8],  head_i.raw[7:0]);
      vec_b   = '0;
      last_d  = 1'b1;
    end else begin
      vec_a   = unpack_group(head_i.raw[RawW-1:64]);
      vec_b   = unpack_group(head_i.raw[63:0]);
      last_d  = 1'b0;
    end
    kind_d = head_i.kind;
    data_d = {vec_b.z, vec_b.y, vec_b.x, vec_a.z, vec_a.y, vec_a.x,
              head_i.sample_index, head_i.temperature, head_i.timestamp,
              head_i.num_samples};
    valid_d = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Output beat payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      kind_q <= kind_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_kind_o  = kind_q;
  assign out_last_o  = last_q;

  `IMU_UNP_ASSERT(a_mag_last, !valid_q || (kind_q == last_q), "last must mark magnetometer beat only")

endmodule

`default_nettype wire
